@@ hw/rtl/baro_sensor_compensation_unit_macros.svh @@
// Assertion macros for the barometric compensation unit checks.
`ifndef BARO_SENSOR_COMPENSATION_UNIT_MACROS_SVH
`define BARO_SENSOR_COMPENSATION_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define BSC_ASSERT_NOW(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");

// Antecedent implies consequent a fixed number of cycles later.
`define BSC_ASSERT_DELAY(label, clk, rst_n, a, n, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (c)) \
        else $error("check failed");

`endif

@@ hw/rtl/bsc_pkg.sv @@
// Shared constants, codes and helpers of the barometric compensation unit.
package bsc_pkg;

    localparam int DATA_W         = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int OVERSAMPLING_D = 0;
    // Register stages from accept to result: 3 front, 32 divide, 5 middle,
    // 32 divide, 3 back.
    localparam int LATENCY        = 75;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AC1   = 3'd0,
        REG_AC2   = 3'd1,
        REG_AC3   = 3'd2,
        REG_AC4   = 3'd3,
        REG_AC5   = 3'd4,
        REG_AC6   = 3'd5,
        REG_B1_B2 = 3'd6,
        REG_MC_MD = 3'd7
    } cfg_index_t;

    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_TEMP_0 = 2'd1;
    localparam logic [1:0] ERR_PRES_0 = 2'd2;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
        return $unsigned($signed(v) >>> n);
    endfunction

endpackage

@@ hw/rtl/baro_sensor_compensation_unit.sv @@
// Top level of the barometric sensor compensation unit.
//
// Usage: pulse start with raw_temperature and raw_pressure; busy is never
// raised, so an item is taken in every cycle that start is high.
// Each item gives one result: done is high for one cycle with
// temperature_tenths (0.1 degC), pressure_pa and error_code.
// Throughput is one item per cycle. The pipeline is made of two
// 32-stage pipelined dividers (temperature x2 and pressure p), one
// quotient bit per stage, plus 11 stages of 32-bit multiply and adjust.
// Calibration registers are written through cfg_we/cfg_index/cfg_data
// with no wait; write them only while no item is in flight.
// Reset clears all calibration registers and drops every item in flight.
// The receiver cannot stall: results are shown once and never held.
// A zero temperature divisor gives error_code 1 with zero outputs; a
// zero pressure divisor gives error_code 2 with pressure 0.
module baro_sensor_compensation_unit #(
    parameter int OVERSAMPLING = bsc_pkg::OVERSAMPLING_D
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [15:0]                  raw_temperature,
    input  logic [18:0]                  raw_pressure,
    output logic                         done,
    output logic signed [15:0]           temperature_tenths,
    output logic [23:0]                  pressure_pa,
    output logic [1:0]                   error_code,
    input  logic                         cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bsc_pkg::DATA_W-1:0]   cfg_data
);

    import bsc_pkg::*;

    localparam int S1_W = 32 + 19 + 1 + 1;
    localparam int S2_W = 16 + 1 + 1 + 1;
    localparam logic [31:0] PSCALE = 32'(50000 >> OVERSAMPLING);

    // Calibration registers
    logic [15:0] ac1_reg, ac2_reg, ac3_reg, ac4_reg, ac5_reg, ac6_reg;
    logic [31:0] b1b2_reg, mcmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac1_reg  <= '0;
            ac2_reg  <= '0;
            ac3_reg  <= '0;
            ac4_reg  <= '0;
            ac5_reg  <= '0;
            ac6_reg  <= '0;
            b1b2_reg <= '0;
            mcmd_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_AC1:   ac1_reg  <= cfg_data[15:0];
                REG_AC2:   ac2_reg  <= cfg_data[15:0];
                REG_AC3:   ac3_reg  <= cfg_data[15:0];
                REG_AC4:   ac4_reg  <= cfg_data[15:0];
                REG_AC5:   ac5_reg  <= cfg_data[15:0];
                REG_AC6:   ac6_reg  <= cfg_data[15:0];
                REG_B1_B2: b1b2_reg <= cfg_data;
                REG_MC_MD: mcmd_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    logic [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    assign ac1 = sext16(ac1_reg);
    assign ac2 = sext16(ac2_reg);
    assign ac3 = sext16(ac3_reg);
    assign b1  = sext16(b1b2_reg[31:16]);
    assign b2  = sext16(b1b2_reg[15:0]);
    assign mc  = sext16(mcmd_reg[31:16]);
    assign md  = sext16(mcmd_reg[15:0]);

    assign busy = 1'b0;

    logic v0_reg, v1_reg, v2_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic v3_reg, v9_reg, v10_reg, done_reg;
    logic d1_valid, d2_valid;

    // Stage 0: capture the item
    logic [15:0] ut0_reg;
    logic [18:0] up0_reg;
    always_ff @(posedge clk)
    begin
        ut0_reg <= raw_temperature;
        up0_reg <= raw_pressure;
    end

    // Stage 1: (UT - AC6) * AC5
    logic [31:0] tprod_next, tprod_reg;
    logic [18:0] up1_reg;
    assign tprod_next = ({16'd0, ut0_reg} - {16'd0, ac6_reg}) * {16'd0, ac5_reg};
    always_ff @(posedge clk)
    begin
        tprod_reg <= tprod_next;
        up1_reg   <= up0_reg;
    end

    // Stage 2: divisor and magnitudes for the temperature divide
    logic [31:0] x1t_next, tdiv_next, tnum_next, tnum_reg, tden_reg;
    logic [S1_W-1:0] side1_reg;
    assign x1t_next  = asr32(tprod_reg, 15);
    assign tdiv_next = x1t_next + md;
    assign tnum_next = mc << 11;
    always_ff @(posedge clk)
    begin
        tnum_reg  <= tnum_next[31] ? -tnum_next : tnum_next;
        tden_reg  <= tdiv_next[31] ? -tdiv_next : tdiv_next;
        side1_reg <= {x1t_next, up1_reg, (tdiv_next == 32'd0),
                      tnum_next[31] ^ tdiv_next[31]};
    end

    logic [31:0] tquo;
    logic [S1_W-1:0] side1_out;
    bsc_div #(.W(32), .SW(S1_W)) u_tdiv (
        .clk(clk), .rst_n(rst_n),
        .in_valid(v2_reg), .in_num(tnum_reg), .in_den(tden_reg), .in_side(side1_reg),
        .out_valid(d1_valid), .out_quo(tquo), .out_side(side1_out)
    );

    // Stage 3: B5 and saturated temperature
    logic [31:0] x1t_d, x2t_next, b5_next, traw_next, b5_reg;
    logic [18:0] up_d, up3_reg, up4_reg, up5_reg, up6_reg;
    logic        tz_d, neg_d, tz3_reg, tz4_reg, tz5_reg, tz6_reg, tz7_reg;
    logic [15:0] tsat_next, t3_reg, t4_reg, t5_reg, t6_reg, t7_reg;
    assign {x1t_d, up_d, tz_d, neg_d} = side1_out;
    assign x2t_next  = neg_d ? -tquo : tquo;
    assign b5_next   = x1t_d + x2t_next;
    assign traw_next = asr32(b5_next + 32'd8, 4);
    always_comb
    begin
        if ($signed(traw_next) > 32'sd32767)
            tsat_next = 16'h7fff;
        else if ($signed(traw_next) < -32'sd32768)
            tsat_next = 16'h8000;
        else
            tsat_next = traw_next[15:0];
    end
    always_ff @(posedge clk)
    begin
        b5_reg  <= b5_next;
        up3_reg <= up_d;
        tz3_reg <= tz_d;
        t3_reg  <= tsat_next;
    end

    // Stage 4: products of B6
    logic [31:0] b6_next, b6sq_reg, ac2b6_reg, ac3b6_reg;
    assign b6_next = b5_reg - 32'd4000;
    always_ff @(posedge clk)
    begin
        b6sq_reg  <= b6_next * b6_next;
        ac2b6_reg <= ac2 * b6_next;
        ac3b6_reg <= ac3 * b6_next;
        up4_reg   <= up3_reg;
        tz4_reg   <= tz3_reg;
        t4_reg    <= t3_reg;
    end

    // Stage 5: products of the squared term
    logic [31:0] sq_next, b2sq_reg, b1sq_reg, x2a_reg, x1b_reg;
    assign sq_next = asr32(b6sq_reg, 12);
    always_ff @(posedge clk)
    begin
        b2sq_reg <= b2 * sq_next;
        b1sq_reg <= b1 * sq_next;
        x2a_reg  <= asr32(ac2b6_reg, 11);
        x1b_reg  <= asr32(ac3b6_reg, 13);
        up5_reg  <= up4_reg;
        tz5_reg  <= tz4_reg;
        t5_reg   <= t4_reg;
    end

    // Stage 6: B3 and the X3 of B4
    logic [31:0] x3a_next, b3t_next, b3_reg, x3b_reg;
    assign x3a_next = asr32(b2sq_reg, 11) + x2a_reg;
    assign b3t_next = ((ac1 * 32'd4 + x3a_next) << OVERSAMPLING) + 32'd2;
    always_ff @(posedge clk)
    begin
        // Truncating divide by four: round a negative value toward zero.
        b3_reg  <= b3t_next[31] ? asr32(b3t_next + 32'd3, 2) : asr32(b3t_next, 2);
        x3b_reg <= asr32(x1b_reg + asr32(b1sq_reg, 16) + 32'd2, 2);
        up6_reg <= up5_reg;
        tz6_reg <= tz5_reg;
        t6_reg  <= t5_reg;
    end

    // Stage 7: B4 and B7
    logic [31:0] b4p_next, b4_reg, b7_reg;
    assign b4p_next = {16'd0, ac4_reg} * (x3b_reg + 32'd32768);
    always_ff @(posedge clk)
    begin
        b4_reg  <= b4p_next >> 15;
        b7_reg  <= ({13'd0, up6_reg} - b3_reg) * PSCALE;
        tz7_reg <= tz6_reg;
        t7_reg  <= t6_reg;
    end

    logic [31:0] pnum;
    logic [S2_W-1:0] side2_in, side2_out;
    logic [31:0] pquo;
    assign pnum     = b7_reg[31] ? b7_reg : (b7_reg << 1);
    assign side2_in = {t7_reg, tz7_reg, (b4_reg == 32'd0), b7_reg[31]};

    bsc_div #(.W(32), .SW(S2_W)) u_pdiv (
        .clk(clk), .rst_n(rst_n),
        .in_valid(v7_reg), .in_num(pnum), .in_den(b4_reg), .in_side(side2_in),
        .out_valid(d2_valid), .out_quo(pquo), .out_side(side2_out)
    );

    // Stage 9: first correction products
    logic [15:0] t_d, t9_reg, t10_reg;
    logic        tz_d2, pz_d, hi_d, tz9_reg, tz10_reg, pz9_reg, pz10_reg;
    logic [31:0] p_next, s_next, p9_reg, sq9_reg, m9_reg;
    assign {t_d, tz_d2, pz_d, hi_d} = side2_out;
    assign p_next = hi_d ? (pquo << 1) : pquo;
    assign s_next = asr32(p_next, 8);
    always_ff @(posedge clk)
    begin
        p9_reg  <= p_next;
        sq9_reg <= s_next * s_next;
        m9_reg  <= 32'd7357 * p_next;
        t9_reg  <= t_d;
        tz9_reg <= tz_d2;
        pz9_reg <= pz_d;
    end

    // Stage 10: scale the square term
    logic [31:0] p10_reg, x1c_reg, x2c_reg;
    always_ff @(posedge clk)
    begin
        p10_reg  <= p9_reg;
        x1c_reg  <= sq9_reg * 32'd3038;
        x2c_reg  <= asr32(32'd0 - m9_reg, 16);
        t10_reg  <= t9_reg;
        tz10_reg <= tz9_reg;
        pz10_reg <= pz9_reg;
    end

    // Stage 11: final pressure, saturate and select the error
    logic [31:0] pf_next;
    logic [23:0] psat_next;
    logic [15:0] tout_reg;
    logic [23:0] pout_reg;
    logic [1:0]  err_reg;
    assign pf_next = p10_reg + asr32(asr32(x1c_reg, 16) + x2c_reg + 32'd3791, 4);
    always_comb
    begin
        if (pf_next[31])
            psat_next = '0;
        else if (pf_next[30:24] != 7'd0)
            psat_next = 24'hffffff;
        else
            psat_next = pf_next[23:0];
    end
    always_ff @(posedge clk)
    begin
        if (tz10_reg)
        begin
            tout_reg <= '0;
            pout_reg <= '0;
            err_reg  <= ERR_TEMP_0;
        end
        else if (pz10_reg)
        begin
            tout_reg <= t10_reg;
            pout_reg <= '0;
            err_reg  <= ERR_PRES_0;
        end
        else
        begin
            tout_reg <= t10_reg;
            pout_reg <= psat_next;
            err_reg  <= ERR_OK;
        end
    end

    // Valid bits travel with the item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            v9_reg   <= 1'b0;
            v10_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= start && !busy;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            v3_reg   <= d1_valid;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            v7_reg   <= v6_reg;
            v9_reg   <= d2_valid;
            v10_reg  <= v9_reg;
            done_reg <= v10_reg;
        end
    end

    assign done               = done_reg;
    assign temperature_tenths = tout_reg;
    assign pressure_pa        = pout_reg;
    assign error_code         = err_reg;

endmodule

@@ hw/rtl/bsc_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage.
module bsc_div #(
    parameter int W  = 32,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [W-1:0]  in_num,
    input  logic [W-1:0]  in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [W-1:0]  out_quo,
    output logic [SW-1:0] out_side
);

    logic          vld_reg  [W];
    logic [W-1:0]  num_reg  [W];
    logic [W-1:0]  rem_reg  [W];
    logic [W-1:0]  den_reg  [W];
    logic [SW-1:0] side_reg [W];

    for (genvar i = 0; i < W; i++)
    begin : g_stage
        logic          vld_in;
        logic [W-1:0]  num_in;
        logic [W-1:0]  rem_in;
        logic [W-1:0]  den_in;
        logic [SW-1:0] side_in;
        logic [W:0]    trial;

        if (i == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign num_in  = in_num;
            assign rem_in  = '0;
            assign den_in  = in_den;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[i-1];
            assign num_in  = num_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign den_in  = den_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        assign trial = {rem_in, num_in[W-1]} - {1'b0, den_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else
            begin
                vld_reg[i] <= vld_in;
            end
        end

        // Keep the shifted partial remainder when the trial borrows.
        always_ff @(posedge clk)
        begin
            rem_reg[i]  <= trial[W] ? {rem_in[W-2:0], num_in[W-1]} : trial[W-1:0];
            num_reg[i]  <= {num_in[W-2:0], ~trial[W]};
            den_reg[i]  <= den_in;
            side_reg[i] <= side_in;
        end
    end

    assign out_valid = vld_reg[W-1];
    assign out_quo   = num_reg[W-1];
    assign out_side  = side_reg[W-1];

endmodule

@@ hw/rtl/bsc_checker.sv @@
// Port-level checks of the barometric compensation unit, bound to the top level.
`include "baro_sensor_compensation_unit_macros.svh"

module bsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [15:0] temperature_tenths,
    input logic [23:0] pressure_pa,
    input logic [1:0]  error_code
);

    import bsc_pkg::*;

    `BSC_ASSERT_DELAY(a_latency, clk, rst_n, start && !busy, LATENCY, done)
    `BSC_ASSERT_NOW(a_err_code, clk, rst_n, done, error_code != 2'd3)
    `BSC_ASSERT_NOW(a_temp_zero, clk, rst_n, done && (error_code == ERR_TEMP_0), (temperature_tenths == 16'd0) && (pressure_pa == 24'd0))
    `BSC_ASSERT_NOW(a_pres_zero, clk, rst_n, done && (error_code == ERR_PRES_0), pressure_pa == 24'd0)

endmodule

bind baro_sensor_compensation_unit bsc_checker u_bsc_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .done(done),
    .temperature_tenths(temperature_tenths),
    .pressure_pa(pressure_pa),
    .error_code(error_code)
);
